@@ rtl/twin_rotor_pitch_plant_rk4_step_assert.svh @@
// Assertion macros for the twin-rotor pitch plant step block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TWIN_ROTOR_PITCH_PLANT_RK4_STEP_ASSERT_SVH
`define TWIN_ROTOR_PITCH_PLANT_RK4_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRPP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/trpp_pkg.sv @@
// Shared types, coefficients and the micro-program for the pitch plant step.
// No dependencies; imported by trpp_mul, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package trpp_pkg;

    localparam int WORD_W = 48;

    localparam logic [6:0] COEF_SH  = 7'd56;
    localparam logic [6:0] RECIP_SH = 7'd55;

    localparam logic signed [63:0] LIM_POS = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM_NEG = 64'shFFFF_8000_0000_0000;

    // Coefficients with 56 fraction bits, step size folded in
    localparam logic signed [63:0] K_HA  = 64'sd86767282200165235;
    localparam logic signed [63:0] K_HB  = 64'sd87557483455514;
    localparam logic signed [63:0] K_HC  = 64'sd51848469360;
    localparam logic signed [63:0] K_HD  = 64'sd233530045400000;
    localparam logic signed [63:0] K_HQQ = 64'sd1109686948;
    localparam logic signed [63:0] K_HQL = 64'sd3124177990000;
    localparam logic signed [63:0] K_HT  = 64'sd7205759403793;
    // ceil(2^55 / 6): exact floor division by six for magnitudes below 2^53
    localparam logic signed [63:0] K_R6  = 64'sd6004799503160662;

    typedef enum logic [3:0] {
        OP_MOV, OP_ADD, OP_SUB, OP_SUBNS, OP_ADDH, OP_ADD2, OP_ADDNS, OP_BIAS3, OP_MUL
    } op_kind_t;

    typedef enum logic [1:0] {MD_ANY, MD_QUAD, MD_LIN, MD_NONE} op_mode_t;

    typedef enum logic [1:0] {SH_COEF, SH_FRAC, SH_RECIP} sh_sel_t;

    typedef logic [4:0] src_t;

    // Operand space: state and inputs, scratch memory, constants
    localparam src_t R_WF  = 5'd0;
    localparam src_t R_WR  = 5'd1;
    localparam src_t R_Q   = 5'd2;
    localparam src_t R_TH  = 5'd3;
    localparam src_t R_UF  = 5'd4;
    localparam src_t R_UR  = 5'd5;
    localparam src_t R_X   = 5'd8;
    localparam src_t R_DRV = 5'd9;
    localparam src_t R_XT  = 5'd10;
    localparam src_t R_K   = 5'd11;
    localparam src_t R_ACC = 5'd12;
    localparam src_t R_T1  = 5'd13;
    localparam src_t R_T2  = 5'd14;
    localparam src_t C_HA  = 5'd16;
    localparam src_t C_HB  = 5'd17;
    localparam src_t C_HC  = 5'd18;
    localparam src_t C_HD  = 5'd19;
    localparam src_t C_HQQ = 5'd20;
    localparam src_t C_HQL = 5'd21;
    localparam src_t C_HT  = 5'd22;
    localparam src_t C_R6  = 5'd23;

    localparam logic [5:0] PITCH_LAST = 6'd9;
    localparam logic [5:0] MOTOR_LAST = 6'd40;

    typedef struct packed {
        op_kind_t kind;
        op_mode_t mode;
        src_t     dst;
        src_t     sa;
        src_t     sb;
        sh_sel_t  sh;
        logic     rnd;
    } op_t;

    typedef struct packed {
        logic       start;
        logic       rnd;
        logic [6:0] sh;
    } mul_ctl_t;

    function automatic op_t mk(op_kind_t k, op_mode_t m, src_t d, src_t a, src_t b,
                               sh_sel_t s, logic r);
        op_t o;
        o.kind = k;
        o.mode = m;
        o.dst  = d;
        o.sa   = a;
        o.sb   = b;
        o.sh   = s;
        o.rnd  = r;
        return o;
    endfunction

    function automatic logic signed [63:0] const_val(src_t s);
        logic signed [63:0] v;
        case (s)
            C_HA:    v = K_HA;
            C_HB:    v = K_HB;
            C_HC:    v = K_HC;
            C_HD:    v = K_HD;
            C_HQQ:   v = K_HQQ;
            C_HQL:   v = K_HQL;
            C_HT:    v = K_HT;
            C_R6:    v = K_R6;
            default: v = 64'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] sat48(logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > LIM_POS)
            r = LIM_POS;
        else if (v < LIM_NEG)
            r = LIM_NEG;
        else
            r = v;
        return r;
    endfunction

    // One evaluation of the motor derivative at trial speed XT into K
    function automatic op_t eval_op(logic [2:0] e);
        op_t o;
        case (e)
            3'd0:    o = mk(OP_MUL,   MD_QUAD, R_T1, C_HB,  R_XT, SH_COEF, 1'b1);
            3'd1:    o = mk(OP_MUL,   MD_QUAD, R_T2, C_HC,  R_XT, SH_COEF, 1'b1);
            3'd2:    o = mk(OP_MUL,   MD_QUAD, R_T2, R_T2,  R_XT, SH_FRAC, 1'b1);
            3'd3:    o = mk(OP_MUL,   MD_LIN,  R_T1, C_HD,  R_XT, SH_COEF, 1'b1);
            3'd4:    o = mk(OP_SUBNS, MD_QUAD, R_K,  R_DRV, R_T1, SH_COEF, 1'b0);
            3'd5:    o = mk(OP_SUB,   MD_LIN,  R_K,  R_DRV, R_T1, SH_COEF, 1'b0);
            3'd6:    o = mk(OP_SUB,   MD_QUAD, R_K,  R_K,   R_T2, SH_COEF, 1'b0);
            default: o = mk(OP_MOV,   MD_NONE, R_X,  R_X,   R_X,  SH_COEF, 1'b0);
        endcase
        return o;
    endfunction

    // Full RK4 step of one motor: speed register w, voltage register u
    function automatic op_t motor_op(logic [5:0] step, src_t w, src_t u);
        op_t        o;
        logic [2:0] e;
        if (step >= 6'd30)
            e = 3'(step - 6'd30);
        else if (step >= 6'd21)
            e = 3'(step - 6'd21);
        else if (step >= 6'd12)
            e = 3'(step - 6'd12);
        else
            e = 3'(step - 6'd3);
        case (step)
            6'd0:  o = mk(OP_MOV,   MD_ANY, R_X,   w,     R_X,  SH_COEF,  1'b0);
            6'd1:  o = mk(OP_MUL,   MD_ANY, R_DRV, C_HA,  u,    SH_COEF,  1'b1);
            6'd2:  o = mk(OP_MOV,   MD_ANY, R_XT,  R_X,   R_X,  SH_COEF,  1'b0);
            6'd10: o = mk(OP_MOV,   MD_ANY, R_ACC, R_K,   R_K,  SH_COEF,  1'b0);
            6'd11: o = mk(OP_ADDH,  MD_ANY, R_XT,  R_X,   R_K,  SH_COEF,  1'b0);
            6'd19: o = mk(OP_ADD2,  MD_ANY, R_ACC, R_ACC, R_K,  SH_COEF,  1'b0);
            6'd20: o = mk(OP_ADDH,  MD_ANY, R_XT,  R_X,   R_K,  SH_COEF,  1'b0);
            6'd28: o = mk(OP_ADD2,  MD_ANY, R_ACC, R_ACC, R_K,  SH_COEF,  1'b0);
            6'd29: o = mk(OP_ADD,   MD_ANY, R_XT,  R_X,   R_K,  SH_COEF,  1'b0);
            6'd37: o = mk(OP_ADDNS, MD_ANY, R_ACC, R_ACC, R_K,  SH_COEF,  1'b0);
            6'd38: o = mk(OP_BIAS3, MD_ANY, R_ACC, R_ACC, R_K,  SH_COEF,  1'b0);
            6'd39: o = mk(OP_MUL,   MD_ANY, R_T1,  R_ACC, C_R6, SH_RECIP, 1'b0);
            6'd40: o = mk(OP_ADD,   MD_ANY, w,     R_X,   R_T1, SH_COEF,  1'b0);
            default:
            begin
                if (step > MOTOR_LAST)
                    o = mk(OP_MOV, MD_NONE, R_X, R_X, R_X, SH_COEF, 1'b0);
                else
                    o = eval_op(e);
            end
        endcase
        return o;
    endfunction

    // Pitch angle from the rate, then pitch rate from the speeds, both as before the tick
    function automatic op_t pitch_op(logic [5:0] step);
        op_t o;
        case (step)
            6'd0:    o = mk(OP_MUL, MD_ANY,  R_T1, C_HT,  R_Q,  SH_COEF, 1'b1);
            6'd1:    o = mk(OP_ADD, MD_ANY,  R_TH, R_TH,  R_T1, SH_COEF, 1'b0);
            6'd2:    o = mk(OP_MUL, MD_QUAD, R_T1, C_HQQ, R_WF, SH_COEF, 1'b1);
            6'd3:    o = mk(OP_MUL, MD_QUAD, R_T1, R_T1,  R_WF, SH_FRAC, 1'b1);
            6'd4:    o = mk(OP_MUL, MD_QUAD, R_T2, C_HQQ, R_WR, SH_COEF, 1'b1);
            6'd5:    o = mk(OP_MUL, MD_QUAD, R_T2, R_T2,  R_WR, SH_FRAC, 1'b1);
            6'd6:    o = mk(OP_SUB, MD_QUAD, R_T1, R_T1,  R_T2, SH_COEF, 1'b0);
            6'd7:    o = mk(OP_SUB, MD_LIN,  R_T1, R_WF,  R_WR, SH_COEF, 1'b0);
            6'd8:    o = mk(OP_MUL, MD_LIN,  R_T1, C_HQL, R_T1, SH_COEF, 1'b1);
            6'd9:    o = mk(OP_ADD, MD_ANY,  R_Q,  R_Q,   R_T1, SH_COEF, 1'b0);
            default: o = mk(OP_MOV, MD_NONE, R_X,  R_X,   R_X,  SH_COEF, 1'b0);
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

@@ rtl/trpp_mul.sv @@
// Multi-cycle signed fractional multiplier: 32x32 partial products, round, saturate.
// Depends on trpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trpp_mul
    import trpp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mul_ctl_t           ctl,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic                    done,
    output logic signed [63:0]      result
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } mstate_t;

    mstate_t            mstate_reg;
    logic [2:0]         cnt_reg;
    logic               neg_reg;
    logic [63:0]        ma_reg;
    logic [63:0]        mb_reg;
    logic [6:0]         sh_reg;
    logic               rnd_reg;
    logic [63:0]        pp_reg;
    logic [127:0]       acc_reg;
    logic               done_reg;
    logic signed [63:0] res_reg;

    logic [1:0]         pc;
    logic [127:0]       pp_wide;
    logic [31:0]        op_x;
    logic [31:0]        op_y;
    logic [127:0]       rounded;
    logic [127:0]       shifted;
    logic [47:0]        mag;
    logic [63:0]        mag64;
    logic signed [63:0] res_next;

    always_comb
    begin
        op_x = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        op_y = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pc   = 2'(cnt_reg - 3'd1);
        pp_wide = {64'd0, pp_reg};
        if (pc == 2'd3)
            pp_wide = pp_wide << 64;
        else if (pc != 2'd0)
            pp_wide = pp_wide << 32;
    end

    // Round half away from zero on the magnitude when rnd is set, then clamp to 48 bits
    always_comb
    begin
        rounded = acc_reg + (rnd_reg ? (128'd1 << (sh_reg - 7'd1)) : 128'd0);
        shifted = rounded >> sh_reg;
        if ((|shifted[127:48]) || (shifted[47] && (|shifted[46:0])))
            mag = 48'h8000_0000_0000;
        else
            mag = shifted[47:0];
        mag64 = {16'd0, mag};
        if (neg_reg)
            res_next = $signed(64'd0 - mag64);
        else if (mag[47])
            res_next = LIM_POS;
        else
            res_next = $signed(mag64);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstate_reg <= M_IDLE;
            cnt_reg    <= 3'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (mstate_reg)
                M_IDLE:
                begin
                    if (ctl.start)
                    begin
                        cnt_reg    <= 3'd0;
                        mstate_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4)
                        mstate_reg <= M_FIN;
                end
                M_FIN:
                begin
                    done_reg   <= 1'b1;
                    mstate_reg <= M_IDLE;
                end
                default:
                begin
                    mstate_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mstate_reg == M_IDLE && ctl.start)
        begin
            neg_reg <= a[63] ^ b[63];
            ma_reg  <= a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
            mb_reg  <= b[63] ? (64'd0 - $unsigned(b)) : $unsigned(b);
            sh_reg  <= ctl.sh;
            rnd_reg <= ctl.rnd;
            acc_reg <= 128'd0;
        end
        if (mstate_reg == M_RUN)
        begin
            if (cnt_reg != 3'd4)
                pp_reg <= 64'(op_x * op_y);
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_wide;
        end
        if (mstate_reg == M_FIN)
            res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ rtl/twin_rotor_pitch_plant_rk4_step.sv @@
// Twin-rotor pitch plant: one RK4 tick per item, run by a micro-sequencer.
// Depends on trpp_pkg, trpp_mul and twin_rotor_pitch_plant_rk4_step_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one item carries the front and rear
//   motor voltages for one tick. An item is taken when in_valid is high and
//   in_stall is low. in_stall stays high from the accept until the tick's
//   micro-program has run to its end and its result is in the output register.
//   Output channel (out_valid / out_stall): one item per tick with the four
//   new states. An output register holds it, so the next input item can be
//   taken while it waits; if the receiver stalls, the next tick finishes its
//   arithmetic and then holds until the output register is free.
//   Each multiply-class step runs through the single shared multiplier and
//   waits in S_MULW for its result, each add-class step goes through the
//   adder in S_READ and S_EXEC, and a step skipped for the current mode only
//   passes through S_READ; the multiplier sets the rate.
//   Configuration: cfg_we with cfg_wdata selects quadratic drag (1) or the
//   model linearized about hover (0); write only while idle.
//   Reset: all four states and the mode clear to zero, no item pending.
`timescale 1ns / 1ps
`default_nettype none

`include "twin_rotor_pitch_plant_rk4_step_assert.svh"

module twin_rotor_pitch_plant_rk4_step
    import trpp_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [47:0] front_voltage,
    input  wire logic signed [47:0] rear_voltage,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [47:0]      front_speed_out,
    output logic signed [47:0]      rear_speed_out,
    output logic signed [47:0]      pitch_rate_out,
    output logic signed [47:0]      pitch_angle_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_MULW = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        PH_PITCH = 3'b001,
        PH_FRONT = 3'b010,
        PH_REAR  = 3'b100
    } phase_t;

    localparam logic [6:0] FRAC_SH = 7'(FRAC_BITS);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [5:0] step_reg, step_next;
    logic mode_reg;

    logic signed [WORD_W-1:0] wf_reg, wr_reg, q_reg, th_reg;
    logic signed [WORD_W-1:0] uf_reg, ur_reg;

    logic signed [63:0] mem [0:7];
    logic signed [63:0] rd_a_reg, rd_b_reg;

    logic signed [WORD_W-1:0] fs_out_reg, rs_out_reg, pr_out_reg, pa_out_reg;
    logic out_valid_reg;

    op_t                op;
    logic               skip;
    logic               last;
    logic               adv;
    logic signed [63:0] a_val, b_val;
    logic signed [63:0] opnd, sum, alu_res;
    logic               wr_en;
    logic signed [63:0] wr_data;
    mul_ctl_t           mul_ctl;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               in_acc;
    logic               fin_load;

    // Current micro-op
    always_comb
    begin
        case (phase_reg)
            PH_PITCH: op = pitch_op(step_reg);
            PH_FRONT: op = motor_op(step_reg, R_WF, R_UF);
            PH_REAR:  op = motor_op(step_reg, R_WR, R_UR);
            default:  op = pitch_op(step_reg);
        endcase
        skip = (op.mode == MD_NONE) || (op.mode == MD_QUAD && !mode_reg)
            || (op.mode == MD_LIN && mode_reg);
        last = (phase_reg == PH_PITCH) ? (step_reg == PITCH_LAST) : (step_reg == MOTOR_LAST);
    end

    // Operand fetch: state and inputs, scratch memory, or constants
    always_comb
    begin
        case (op.sa[4:3])
            2'b00:
            begin
                case (op.sa[2:0])
                    3'd0:    a_val = 64'(wf_reg);
                    3'd1:    a_val = 64'(wr_reg);
                    3'd2:    a_val = 64'(q_reg);
                    3'd3:    a_val = 64'(th_reg);
                    3'd4:    a_val = 64'(uf_reg);
                    3'd5:    a_val = 64'(ur_reg);
                    default: a_val = 64'sd0;
                endcase
            end
            2'b01:   a_val = rd_a_reg;
            2'b10:   a_val = const_val(op.sa);
            default: a_val = 64'sd0;
        endcase
        case (op.sb[4:3])
            2'b00:
            begin
                case (op.sb[2:0])
                    3'd0:    b_val = 64'(wf_reg);
                    3'd1:    b_val = 64'(wr_reg);
                    3'd2:    b_val = 64'(q_reg);
                    3'd3:    b_val = 64'(th_reg);
                    3'd4:    b_val = 64'(uf_reg);
                    3'd5:    b_val = 64'(ur_reg);
                    default: b_val = 64'sd0;
                endcase
            end
            2'b01:   b_val = rd_b_reg;
            2'b10:   b_val = const_val(op.sb);
            default: b_val = 64'sd0;
        endcase
    end

    // One adder; the op picks the second operand and whether to clamp
    always_comb
    begin
        case (op.kind)
            OP_ADD, OP_ADDNS: opnd = b_val;
            OP_SUB, OP_SUBNS: opnd = -b_val;
            OP_ADDH:          opnd = b_val >>> 1;
            OP_ADD2:          opnd = b_val <<< 1;
            OP_BIAS3:         opnd = a_val[63] ? -64'sd3 : 64'sd3;
            default:          opnd = 64'sd0;
        endcase
        sum = a_val + opnd;
        case (op.kind)
            OP_ADD, OP_SUB, OP_ADDH: alu_res = sat48(sum);
            default:                 alu_res = sum;
        endcase
    end

    always_comb
    begin
        mul_ctl.start = (state_reg == S_EXEC) && (op.kind == OP_MUL);
        mul_ctl.rnd   = op.rnd;
        case (op.sh)
            SH_FRAC:  mul_ctl.sh = FRAC_SH;
            SH_RECIP: mul_ctl.sh = RECIP_SH;
            default:  mul_ctl.sh = COEF_SH;
        endcase
    end

    trpp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .a      (a_val),
        .b      (b_val),
        .done   (mul_done),
        .result (mul_res)
    );

    // Write-back from the adder or the multiplier
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = alu_res;
        if (state_reg == S_EXEC && op.kind != OP_MUL)
            wr_en = 1'b1;
        if (state_reg == S_MULW && mul_done)
        begin
            wr_en   = 1'b1;
            wr_data = mul_res;
        end
    end

    assign in_acc   = in_valid && !in_stall;
    assign fin_load = (state_reg == S_FIN) && !out_valid_reg;
    assign adv      = ((state_reg == S_READ) && skip) || (wr_en);

    // Sequencer: walk pitch, front motor, rear motor programs
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                    phase_next = PH_PITCH;
                    step_next  = 6'd0;
                end
            end
            S_READ:
            begin
                if (!skip)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (op.kind == OP_MUL)
                    state_next = S_MULW;
            end
            S_MULW:
            begin
            end
            S_FIN:
            begin
                if (!out_valid_reg)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (adv)
        begin
            state_next = S_READ;
            if (last)
            begin
                step_next = 6'd0;
                case (phase_reg)
                    PH_PITCH: phase_next = PH_FRONT;
                    PH_FRONT: phase_next = PH_REAR;
                    default:  state_next = S_FIN;
                endcase
            end
            else
                step_next = step_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_PITCH;
            step_reg      <= 6'd0;
            mode_reg      <= 1'b0;
            wf_reg        <= '0;
            wr_reg        <= '0;
            q_reg         <= '0;
            th_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            if (cfg_we)
                mode_reg <= cfg_wdata;
            // Commit state results; scratch targets go to the memory
            if (wr_en && !op.dst[3])
            begin
                case (op.dst[1:0])
                    2'd0:    wf_reg <= wr_data[WORD_W-1:0];
                    2'd1:    wr_reg <= wr_data[WORD_W-1:0];
                    2'd2:    q_reg  <= wr_data[WORD_W-1:0];
                    default: th_reg <= wr_data[WORD_W-1:0];
                endcase
            end
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Scratch memory, input capture and output register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            uf_reg <= front_voltage;
            ur_reg <= rear_voltage;
        end
        if (state_reg == S_READ)
        begin
            rd_a_reg <= mem[op.sa[2:0]];
            rd_b_reg <= mem[op.sb[2:0]];
        end
        if (wr_en && op.dst[3])
            mem[op.dst[2:0]] <= wr_data;
        if (fin_load)
        begin
            fs_out_reg <= wf_reg;
            rs_out_reg <= wr_reg;
            pr_out_reg <= q_reg;
            pa_out_reg <= th_reg;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign front_speed_out = fs_out_reg;
    assign rear_speed_out  = rs_out_reg;
    assign pitch_rate_out  = pr_out_reg;
    assign pitch_angle_out = pa_out_reg;

    `TRPP_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == S_READ && phase_reg == PH_PITCH && step_reg == 6'd0, "accept did not start the pitch program")
    `TRPP_ASSERT_SAME(a_mul_done_waited, mul_done, state_reg == S_MULW, "multiplier result with no step waiting")
    `TRPP_ASSERT_NEXT(a_mul_not_instant, mul_ctl.start, !mul_done, "multiplier finished one cycle after start")

endmodule

`default_nettype wire

@@ tb/twin_rotor_pitch_plant_rk4_step_test.sv @@
// Self-checking testbench for twin_rotor_pitch_plant_rk4_step.
// Depends on trpp_pkg (coefficients) and the RTL top level; a built-in plant
// predictor checks every output item against one RK4 tick.
`timescale 1ns / 1ps

module twin_rotor_pitch_plant_rk4_step_test;
    import trpp_pkg::*;

    typedef logic signed [63:0] wide_t;
    typedef logic signed [47:0] word_t;

    localparam word_t MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam word_t MIN48 = 48'sh8000_0000_0000;
    localparam word_t VOLT1 = 48'sh0001_0000_0000;   // 1 V
    localparam int    CYCLE_LIMIT = 3_000_000;
    localparam int    DRAIN_CYCLES = 450;            // about one quadratic tick
    localparam int    HOLD_CYCLES = 3000;
    localparam int    PHASE_ITEMS = 117;

    // Four plant states as one output item
    typedef struct packed {
        word_t front_speed;
        word_t rear_speed;
        word_t pitch_rate;
        word_t pitch_angle;
    } plant_state_t;

    // One directed row: mode, voltages, and a typed-in result where obvious
    typedef struct packed {
        logic         quad;
        word_t        front_v;
        word_t        rear_v;
        logic         known;
        plant_state_t known_state;
    } tick_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_we = 1'b0;
    logic  cfg_wdata = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t front_voltage = '0;
    word_t rear_voltage = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t front_speed_out;
    word_t rear_speed_out;
    word_t pitch_rate_out;
    word_t pitch_angle_out;

    // Predictor state: plant after every accepted item, and the drag mode
    wide_t plant_wf, plant_wr, plant_q, plant_th;
    logic  plant_quad;

    plant_state_t expected_states[$];
    int           fail_cnt = 0;
    int           cycle_cnt = 0;
    int           checked_cnt = 0;

    twin_rotor_pitch_plant_rk4_step uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .front_voltage(front_voltage), .rear_voltage(rear_voltage),
        .out_valid(out_valid), .out_stall(out_stall),
        .front_speed_out(front_speed_out), .rear_speed_out(rear_speed_out),
        .pitch_rate_out(pitch_rate_out), .pitch_angle_out(pitch_angle_out)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic wide_t clamp48(wide_t v);
        wide_t r;
        r = v;
        if (v > LIM_POS)
            r = LIM_POS;
        else if (v < LIM_NEG)
            r = LIM_NEG;
        return r;
    endfunction

    // Exact product, shift with round half away from zero, clamp to 48 bits
    function automatic wide_t scale_mul(wide_t a, wide_t b, int sh);
        logic [127:0] ua, ub, p;
        logic         neg;
        wide_t        r;
        neg = (a < 0) != (b < 0);
        ua = {64'd0, (a < 0) ? -a : a};
        ub = {64'd0, (b < 0) ? -b : b};
        p = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'h8000_0000_0000)
            p = 128'h8000_0000_0000;
        if (neg)
            r = -wide_t'(p[63:0]);
        else if (p > 128'h7FFF_FFFF_FFFF)
            r = LIM_POS;
        else
            r = wide_t'(p[63:0]);
        return r;
    endfunction

    // Motor speed derivative times h at trial speed x
    function automatic wide_t speed_slope(wide_t x, wide_t drive, logic quad);
        wide_t lin, sq;
        if (quad)
        begin
            lin = scale_mul(K_HB, x, 56);
            sq = scale_mul(scale_mul(K_HC, x, 56), x, 32);
            return clamp48(drive - lin - sq);
        end
        return clamp48(drive - scale_mul(K_HD, x, 56));
    endfunction

    function automatic wide_t rk4_speed(wide_t x, wide_t u, logic quad);
        wide_t drive, k1, k2, k3, k4, s, d;
        drive = scale_mul(K_HA, u, 56);
        k1 = speed_slope(x, drive, quad);
        k2 = speed_slope(clamp48(x + (k1 >>> 1)), drive, quad);
        k3 = speed_slope(clamp48(x + (k2 >>> 1)), drive, quad);
        k4 = speed_slope(clamp48(x + k3), drive, quad);
        s = k1 + 2 * k2 + 2 * k3 + k4;
        // Divide by six, rounding half away from zero
        d = (s >= 0) ? (s + 3) / 6 : -((-s + 3) / 6);
        return clamp48(x + d);
    endfunction

    // Advance the predicted plant by one tick and queue the resulting item
    task automatic advance_plant(input word_t fv, input word_t rv);
        wide_t dq, pf, pr;
        plant_state_t st;
        if (plant_quad)
        begin
            pf = scale_mul(scale_mul(K_HQQ, plant_wf, 56), plant_wf, 32);
            pr = scale_mul(scale_mul(K_HQQ, plant_wr, 56), plant_wr, 32);
            dq = clamp48(pf - pr);
        end
        else
            dq = scale_mul(K_HQL, clamp48(plant_wf - plant_wr), 56);
        // Angle integrates the rate from before the tick
        plant_th = clamp48(plant_th + scale_mul(K_HT, plant_q, 56));
        plant_q = clamp48(plant_q + dq);
        plant_wf = rk4_speed(plant_wf, wide_t'(fv), plant_quad);
        plant_wr = rk4_speed(plant_wr, wide_t'(rv), plant_quad);
        st.front_speed = plant_wf[47:0];
        st.rear_speed = plant_wr[47:0];
        st.pitch_rate = plant_q[47:0];
        st.pitch_angle = plant_th[47:0];
        expected_states.push_back(st);
    endtask

    // Offer one item, hold it until accepted, then predict its result.
    // Valid stays high on return; the caller drops it or offers the next.
    task automatic send_tick(input word_t fv, input word_t rv);
        in_valid <= 1'b1;
        front_voltage <= fv;
        rear_voltage <= rv;
        do
            @(posedge clk);
        while (in_stall);
        advance_plant(fv, rv);
    endtask

    // Drop valid, wait for every result, then write the drag mode
    task automatic set_drag_mode(input logic quad);
        in_valid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= quad;
        @(posedge clk);
        plant_quad = quad;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly realistic voltages, some full-range noise, some extremes, some zero
    function automatic word_t pick_voltage();
        logic [63:0] raw;
        int          sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return word_t'($signed(raw[36:0]));        // within about +-16 V
        else if (sel < 8)
            return raw[47:0];
        else if (sel == 8)
            return ($urandom_range(0, 1) != 0) ? MAX48 : MIN48;
        return '0;
    endfunction

    // Receiver: check each accepted item, then pick the next stall value
    int hold_left = 0;
    bit hold_done = 0;
    int stall_pct = 0;
    int pattern_left = 0;

    always @(posedge clk)
    begin
        plant_state_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_states.size() == 0)
            begin
                $error("output item with no expectation waiting");
                fail_cnt++;
            end
            else
            begin
                want = expected_states.pop_front();
                if (front_speed_out !== want.front_speed)
                begin
                    $error("front_speed_out: expected %0d, got %0d",
                           want.front_speed, front_speed_out);
                    fail_cnt++;
                end
                if (rear_speed_out !== want.rear_speed)
                begin
                    $error("rear_speed_out: expected %0d, got %0d",
                           want.rear_speed, rear_speed_out);
                    fail_cnt++;
                end
                if (pitch_rate_out !== want.pitch_rate)
                begin
                    $error("pitch_rate_out: expected %0d, got %0d",
                           want.pitch_rate, pitch_rate_out);
                    fail_cnt++;
                end
                if (pitch_angle_out !== want.pitch_angle)
                begin
                    $error("pitch_angle_out: expected %0d, got %0d",
                           want.pitch_angle, pitch_angle_out);
                    fail_cnt++;
                end
            end
            checked_cnt++;
            // Once, hold off long enough for the block to back up its input
            if (checked_cnt == 120 && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
        end
        if (pattern_left == 0)
        begin
            pattern_left = $urandom_range(20, 2000);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 30;
                2: stall_pct = 70;
                default: stall_pct = 95;
            endcase
        end
        else
            pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    tick_row_t directed_rows[16];

    initial
    begin
        int burst;
        int gap;
        logic phase_modes[6];

        // Zero drive from reset leaves every state at zero
        directed_rows = '{
            '{1'b0, 48'sd0, 48'sd0, 1'b1, '0},
            '{1'b0, 12 * VOLT1, -12 * VOLT1, 1'b0, '0},
            '{1'b0, MAX48, MIN48, 1'b0, '0},
            '{1'b0, MAX48, MAX48, 1'b0, '0},
            '{1'b0, MIN48, MIN48, 1'b0, '0},
            '{1'b0, MIN48, MAX48, 1'b0, '0},
            '{1'b0, 48'sd1, -48'sd1, 1'b0, '0},
            '{1'b0, 48'sd0, 48'sd0, 1'b0, '0},
            '{1'b1, 12 * VOLT1, 6 * VOLT1, 1'b0, '0},
            '{1'b1, -12 * VOLT1, 12 * VOLT1, 1'b0, '0},
            '{1'b1, MAX48, MIN48, 1'b0, '0},
            '{1'b1, MAX48, MAX48, 1'b0, '0},
            '{1'b1, MIN48, MIN48, 1'b0, '0},
            '{1'b1, MIN48, MAX48, 1'b0, '0},
            '{1'b1, -48'sd1, 48'sd1, 1'b0, '0},
            '{1'b1, 48'sd0, 48'sd0, 1'b0, '0}
        };
        phase_modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        plant_wf = 0;
        plant_wr = 0;
        plant_q = 0;
        plant_th = 0;
        plant_quad = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_drag_mode(1'b0);

        // Directed rows, each waits out its own result
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].quad != plant_quad)
                set_drag_mode(directed_rows[i].quad);
            send_tick(directed_rows[i].front_v, directed_rows[i].rear_v);
            if (directed_rows[i].known)
            begin
                expected_states.pop_back();
                expected_states.push_back(directed_rows[i].known_state);
            end
            in_valid <= 1'b0;
            while (expected_states.size() != 0)
                @(posedge clk);
        end

        // Random phases: bursts of items, random gaps, a mode write between phases
        foreach (phase_modes[p])
        begin
            set_drag_mode(phase_modes[p]);
            for (int n = 0; n < PHASE_ITEMS; )
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < PHASE_ITEMS; b++, n++)
                    send_tick(pick_voltage(), pick_voltage());
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 500);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
